/* src/keyed_slot_table_assert.svh */
// ----------------------------------------------------------------------------
// keyed_slot_table_assert.svh
// Assertion macros shared by the keyed slot table modules.
// ----------------------------------------------------------------------------
`ifndef KEYED_SLOT_TABLE_ASSERT_SVH
`define KEYED_SLOT_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

`define KST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define KST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define KST_ASSERT(lbl, clk, rst_n, prop, msg)

`define KST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* src/kst_pkg.sv */
// ----------------------------------------------------------------------------
// kst_pkg
// Shared widths, operation and status codes, and controller/datapath links.
// ----------------------------------------------------------------------------
package kst_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int CMD_W         = 2;
    localparam int KEY_W         = 63;
    localparam int DATA_W        = 64;
    localparam int STATUS_W      = 2;
    localparam int SLOT_IDX_W    = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_GET   = 2'd1,
        CMD_SET   = 2'd2,
        CMD_FREE  = 2'd3
    } kst_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2,
        ST_MISS = 2'd3
    } kst_status_t;

    typedef struct packed {
        logic load;
        logic scan_en;
        logic exec;
    } kst_ctrl_t;

    typedef struct packed {
        logic scan_done;
    } kst_stat_t;

endpackage

/* src/kst_ctrl.sv */
// ----------------------------------------------------------------------------
// kst_ctrl
// Request sequencer: accept, scan the slots, execute, strobe the result.
// ----------------------------------------------------------------------------
module kst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output kst_pkg::kst_ctrl_t ctrl,
    input  kst_pkg::kst_stat_t stat
);
    import kst_pkg::*;

    `include "keyed_slot_table_assert.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl.load    = (state_reg == S_IDLE) && start;
        ctrl.scan_en = (state_reg == S_SCAN);
        ctrl.exec    = (state_reg == S_EXEC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            done_reg  <= (state_next == S_RESP);
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    `KST_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy_reg, busy_reg, "busy not raised")
    `KST_ASSERT_NEXT(a_done_single, clk, rst_n, done_reg, !done_reg, "result strobe held")
    `KST_ASSERT(a_done_busy, clk, rst_n, !done_reg || busy_reg, "result strobe while idle")
    `KST_ASSERT_NEXT(a_done_free, clk, rst_n, done_reg, !busy_reg, "busy held after result")

endmodule

/* src/kst_dp.sv */
// ----------------------------------------------------------------------------
// kst_dp
// Slot storage, sequential key scan and command execution.
// ----------------------------------------------------------------------------
module kst_dp #(
    parameter int NUM_SLOTS = kst_pkg::NUM_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  kst_pkg::kst_ctrl_t             ctrl,
    output kst_pkg::kst_stat_t             stat,
    input  logic [kst_pkg::CMD_W-1:0]      cmd,
    input  logic [kst_pkg::KEY_W-1:0]      owner_key,
    input  logic [kst_pkg::DATA_W-1:0]     data_value,
    output logic [kst_pkg::DATA_W-1:0]     read_value,
    output logic [kst_pkg::STATUS_W-1:0]   status,
    output logic [kst_pkg::SLOT_IDX_W-1:0] slot_index
);
    import kst_pkg::*;

    `include "keyed_slot_table_assert.svh"

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(NUM_SLOTS);

    logic [KEY_W-1:0]  key_mem [NUM_SLOTS];
    logic [DATA_W-1:0] data_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] valid_reg;
    logic [NUM_SLOTS-1:0] valid_next;

    kst_op_t           cmd_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [DATA_W-1:0] value_reg;

    logic [CNT_W-1:0]  scan_cnt_reg;
    logic              cmp_vld_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic [KEY_W-1:0]  key_rd_reg;
    logic              issue;
    logic              match;
    logic              empty;

    logic              hit_found_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic              free_found_reg;
    logic [IDX_W-1:0]  free_idx_reg;

    logic              key_we;
    logic              data_we;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
    kst_status_t       status_next;
    logic [IDX_W-1:0]  idx_next;
    logic              get_ok_next;

    kst_status_t       status_reg;
    logic [SLOT_IDX_W-1:0] slot_index_reg;
    logic              get_ok_reg;
    logic [DATA_W-1:0] data_rd_reg;

    assign issue = ctrl.scan_en && (scan_cnt_reg != SLOTS_C);
    assign match = cmp_vld_reg && valid_reg[cmp_idx_reg] && (key_rd_reg == key_reg);
    assign empty = cmp_vld_reg && !valid_reg[cmp_idx_reg];
    assign stat.scan_done = (scan_cnt_reg == SLOTS_C) && !cmp_vld_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg   <= kst_op_t'(cmd);
            key_reg   <= owner_key;
            value_reg <= data_value;
        end
        if (issue)
        begin
            key_rd_reg  <= key_mem[scan_cnt_reg[IDX_W-1:0]];
            cmp_idx_reg <= scan_cnt_reg[IDX_W-1:0];
        end
        if (match && !hit_found_reg)
        begin
            hit_idx_reg <= cmp_idx_reg;
        end
        if (empty && !free_found_reg)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            scan_cnt_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
            end
            cmp_vld_reg <= issue;
            if (match)
            begin
                hit_found_reg <= 1'b1;
            end
            if (empty)
            begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        valid_next  = valid_reg;
        key_we      = 1'b0;
        data_we     = 1'b0;
        wr_addr     = hit_idx_reg;
        wr_data     = value_reg;
        status_next = ST_OK;
        idx_next    = '0;
        get_ok_next = 1'b0;
        case (cmd_reg)
            CMD_ALLOC:
            begin
                if (hit_found_reg)
                begin
                    status_next = ST_DUP;
                    idx_next    = hit_idx_reg;
                end
                else if (free_found_reg)
                begin
                    valid_next[free_idx_reg] = 1'b1;
                    key_we   = 1'b1;
                    data_we  = 1'b1;
                    wr_addr  = free_idx_reg;
                    wr_data  = '0;
                    idx_next = free_idx_reg;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            CMD_GET:
            begin
                if (hit_found_reg)
                begin
                    idx_next    = hit_idx_reg;
                    get_ok_next = 1'b1;
                end
                else
                begin
                    status_next = ST_MISS;
                end
            end
            CMD_SET:
            begin
                if (hit_found_reg)
                begin
                    idx_next = hit_idx_reg;
                    data_we  = 1'b1;
                end
                else
                begin
                    status_next = ST_MISS;
                end
            end
            CMD_FREE:
            begin
                if (hit_found_reg)
                begin
                    idx_next = hit_idx_reg;
                    valid_next[hit_idx_reg] = 1'b0;
                end
                else
                begin
                    status_next = ST_MISS;
                end
            end
            default:
            begin
                status_next = ST_MISS;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.exec && key_we)
        begin
            key_mem[wr_addr] <= key_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.exec)
        begin
            data_rd_reg <= data_mem[hit_idx_reg];
            if (data_we)
            begin
                data_mem[wr_addr] <= wr_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctrl.exec)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.exec)
        begin
            status_reg     <= status_next;
            slot_index_reg <= SLOT_IDX_W'(idx_next);
            get_ok_reg     <= get_ok_next;
        end
    end

    assign read_value = get_ok_reg ? data_rd_reg : '0;
    assign status     = status_reg;
    assign slot_index = slot_index_reg;

    `KST_ASSERT_NEXT(a_alloc_claims, clk, rst_n, ctrl.exec && (cmd_reg == CMD_ALLOC) && !hit_found_reg && free_found_reg, valid_reg[free_idx_reg], "claimed slot not valid")
    `KST_ASSERT(a_one_slot_change, clk, rst_n, $countones(valid_reg ^ $past(valid_reg)) <= 1, "several slots changed")

endmodule

/* src/keyed_slot_table.sv */
// ----------------------------------------------------------------------------
// keyed_slot_table
// Fully associative key/value table: allocate, get, set and free by key.
//
//  channel   signals                               handshake
//  request   cmd, owner_key, data_value            start & !busy
//  result    read_value, status, slot_index        done (one cycle)
//
//  The key scan reads one slot per cycle into a key read register and checks it
//  in a compare stage; once the scan has drained, the execute state carries out
//  the command, and the result strobe rises in the cycle after it.
//  busy is high from the accept edge until the result strobe ends, so the next
//  request is taken only after the last result has been shown.
//  Reset clears every valid mark at once; key and data memories need no pass.
//  The receiver cannot stall: each result beat is shown for one cycle only.
// ----------------------------------------------------------------------------
module keyed_slot_table #(
    parameter int NUM_SLOTS = kst_pkg::NUM_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [kst_pkg::CMD_W-1:0]      cmd,
    input  logic [kst_pkg::KEY_W-1:0]      owner_key,
    input  logic [kst_pkg::DATA_W-1:0]     data_value,
    output logic                           done,
    output logic [kst_pkg::DATA_W-1:0]     read_value,
    output logic [kst_pkg::STATUS_W-1:0]   status,
    output logic [kst_pkg::SLOT_IDX_W-1:0] slot_index
);
    import kst_pkg::*;

    kst_ctrl_t ctrl;
    kst_stat_t stat;

    kst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctrl  (ctrl),
        .stat  (stat)
    );

    kst_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .stat       (stat),
        .cmd        (cmd),
        .owner_key  (owner_key),
        .data_value (data_value),
        .read_value (read_value),
        .status     (status),
        .slot_index (slot_index)
    );

endmodule

/* tb/keyed_slot_table_tb.sv */
// ----------------------------------------------------------------------------
// keyed_slot_table_tb
// Self-checking bench for the keyed slot table. Requests go in through the
// start/busy handshake in bursts with random gaps. A scoreboard keeps its own
// copy of the slot valid marks, keys and data words, predicts the one result
// beat of each accepted request, and compares every done beat against the
// oldest prediction field by field. A short directed run covers the empty,
// duplicate, miss, reuse and full cases; a random run over a small key pool
// follows, so that most requests hit live slots.
// ----------------------------------------------------------------------------
module keyed_slot_table_tb;

    import kst_pkg::*;

    localparam int SLOTS          = NUM_SLOTS_DEF;
    localparam int POOL_KEYS      = 20;
    localparam int RANDOM_BEATS   = 450;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [DATA_W-1:0]     rd;
        kst_status_t           st;
        logic [SLOT_IDX_W-1:0] idx;
    } slot_result_t;

    class slot_table_scoreboard;
        bit                 occupied [SLOTS];
        logic [KEY_W-1:0]   keys     [SLOTS];
        logic [DATA_W-1:0]  words    [SLOTS];
        slot_result_t       awaited  [$];
        int                 errors;

        function void note(kst_op_t op, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
            slot_result_t r;
            int hit;
            int vacant;
            hit    = -1;
            vacant = -1;
            r.rd   = '0;
            r.st   = ST_OK;
            r.idx  = '0;
            for (int i = SLOTS - 1; i >= 0; i--)
            begin
                if (occupied[i] && keys[i] == k)
                    hit = i;
                if (!occupied[i])
                    vacant = i;
            end
            if (op == CMD_ALLOC)
            begin
                if (hit >= 0)
                begin
                    r.st  = ST_DUP;
                    r.idx = hit[SLOT_IDX_W-1:0];
                end
                else if (vacant < 0)
                    r.st = ST_FULL;
                else
                begin
                    occupied[vacant] = 1'b1;
                    keys[vacant]     = k;
                    words[vacant]    = '0;
                    r.idx            = vacant[SLOT_IDX_W-1:0];
                end
            end
            else if (hit < 0)
                r.st = ST_MISS;
            else
            begin
                r.idx = hit[SLOT_IDX_W-1:0];
                case (op)
                    CMD_GET:  r.rd = words[hit];
                    CMD_SET:  words[hit] = v;
                    default:  occupied[hit] = 1'b0;
                endcase
            end
            awaited.push_back(r);
        endfunction

        function void check(logic [DATA_W-1:0] rd, logic [STATUS_W-1:0] st,
                            logic [SLOT_IDX_W-1:0] idx);
            slot_result_t e;
            if (awaited.size() == 0)
            begin
                $display("%0t: result beat with nothing expected: read_value %h status %0d slot %0d",
                         $time, rd, st, idx);
                errors++;
                return;
            end
            e = awaited.pop_front();
            if (rd !== e.rd)
            begin
                $display("%0t: read_value expected %h got %h", $time, e.rd, rd);
                errors++;
            end
            if (st !== e.st)
            begin
                $display("%0t: status expected %0d got %0d", $time, e.st, st);
                errors++;
            end
            if (idx !== e.idx)
            begin
                $display("%0t: slot_index expected %0d got %0d", $time, e.idx, idx);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  start      = 1'b0;
    logic [CMD_W-1:0]      cmd        = '0;
    logic [KEY_W-1:0]      owner_key  = '0;
    logic [DATA_W-1:0]     data_value = '0;
    logic                  busy;
    logic                  done;
    logic [DATA_W-1:0]     read_value;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_IDX_W-1:0] slot_index;

    slot_table_scoreboard sb = new;
    logic [KEY_W-1:0]     key_pool [POOL_KEYS];
    int                   burst_left = 0;
    int                   stalled    = 0;

    keyed_slot_table uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .owner_key  (owner_key),
        .data_value (data_value),
        .done       (done),
        .read_value (read_value),
        .status     (status),
        .slot_index (slot_index)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic logic [DATA_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        logic [DATA_W-1:0] w;
        w = rand_word();
        return w[KEY_W-1:0];
    endfunction

    // hold start high until the beat is taken, then pace the next burst
    task automatic issue(input kst_op_t op, input logic [KEY_W-1:0] k,
                         input logic [DATA_W-1:0] v);
        int gap;
        start      <= 1'b1;
        cmd        <= op;
        owner_key  <= k;
        data_value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note(op, k, v);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check(read_value, status, slot_index);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stalled = 0;
        else
        begin
            stalled++;
            if (stalled >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        kst_op_t           op;
        logic [KEY_W-1:0]  k;
        logic [DATA_W-1:0] v;
        int                pick;

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_KEYS; i++)
            key_pool[i] = rand_key();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(CMD_GET,   key_pool[0], '0);
        issue(CMD_ALLOC, key_pool[0], '1);
        issue(CMD_ALLOC, key_pool[1], rand_word());
        issue(CMD_ALLOC, key_pool[0], '0);
        issue(CMD_SET,   key_pool[0], '1);
        issue(CMD_SET,   key_pool[1], 64'h8000_0000_0000_0001);
        issue(CMD_GET,   key_pool[0], '0);
        issue(CMD_GET,   key_pool[1], '1);
        issue(CMD_FREE,  rand_key(), '0);
        issue(CMD_SET,   rand_key(), '1);
        issue(CMD_FREE,  key_pool[0], '0);
        issue(CMD_GET,   key_pool[0], '0);
        issue(CMD_ALLOC, key_pool[2], '0);
        issue(CMD_GET,   key_pool[2], '0);
        for (int i = 3; i < SLOTS + 1; i++)
            issue(CMD_ALLOC, key_pool[i], rand_word());
        issue(CMD_ALLOC, key_pool[SLOTS + 1], '0);
        issue(CMD_FREE,  key_pool[1], '0);

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                op = CMD_ALLOC;
            else if (pick < 55)
                op = CMD_GET;
            else if (pick < 80)
                op = CMD_SET;
            else
                op = CMD_FREE;
            k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_KEYS - 1)]
                                              : rand_key();
            pick = $urandom_range(0, 19);
            v = (pick == 0) ? '0 : (pick == 1) ? '1 : rand_word();
            issue(op, k, v);
        end

        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);

        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/kst_pkg.sv
src/kst_ctrl.sv
src/kst_dp.sv
src/keyed_slot_table.sv
tb/keyed_slot_table_tb.sv
